@@ sv/qeb_pkg.sv @@
// qeb_pkg: types and constants shared by the quadrature encoder with button block
// no dependencies; compile first

package qeb_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_READ_COUNT  = 2'd1,
    OP_READ_BUTTON = 2'd2
  } opcode_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STEPS_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS = 2'd1;

  // steps per detent codes
  localparam logic [1:0] MODE_ONE_STEP  = 2'd0;
  localparam logic [1:0] MODE_TWO_STEP  = 2'd1;

  localparam logic [1:0] STEPS_MODE_RST = 2'd0;
  localparam logic [7:0] HOLD_TICKS_RST = 8'd10;

  typedef struct packed {
    logic [1:0] opcode;
    logic       phase_a;
    logic       phase_b;
    logic       button_pressed;
  } in_req_t;

  typedef struct packed {
    logic signed [7:0] count;
    logic              press_event;
  } out_rsp_t;

  // result from the core toward the output stage
  typedef struct packed {
    logic     valid;
    out_rsp_t data;
  } rsp_t;

endpackage

@@ sv/qeb_stream_if.sv @@
// qeb_stream_if: valid/ready channel carrying one payload of type T
// depends on qeb_pkg for the default payload type

interface qeb_stream_if #(
  parameter type T = qeb_pkg::in_req_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/qeb_core.sv @@
// qeb_core: configuration registers, encoder and button state, result logic
// depends on qeb_pkg

module qeb_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qeb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [qeb_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             req_fire_i,
  input  qeb_pkg::in_req_t                 req_i,
  output qeb_pkg::rsp_t                    rsp_o
);
  import qeb_pkg::*;

  logic [1:0] mode_q;
  logic [7:0] hold_ticks_q;
  logic [7:0] delta_q, delta_d;
  logic [1:0] last_q, last_d;
  logic [7:0] hold_q, hold_d;

  logic [1:0] pos;
  logic [1:0] diff;
  logic [7:0] detents;
  logic [7:0] rem_mask;
  logic       press_match;

  // gray decode of the pins, then direction from last minus new
  assign pos  = {req_i.phase_a, req_i.phase_a ^ req_i.phase_b};
  assign diff = last_q - pos;
  assign press_match = (hold_q == hold_ticks_q);

  always_comb begin
    unique case (mode_q)
      MODE_ONE_STEP: begin
        detents  = delta_q;
        rem_mask = 8'h00;
      end
      MODE_TWO_STEP: begin
        detents  = 8'($signed(delta_q) >>> 1);
        rem_mask = 8'h01;
      end
      default: begin
        detents  = 8'($signed(delta_q) >>> 2);
        rem_mask = 8'h03;
      end
    endcase
  end

  always_comb begin
    delta_d = delta_q;
    last_d  = last_q;
    hold_d  = hold_q;
    rsp_o   = '0;
    if (req_fire_i) begin
      unique case (req_i.opcode)
        OP_TICK: begin
          if (req_i.button_pressed) begin
            if (hold_q == 8'd0) begin
              hold_d = hold_ticks_q;
            end
          end else begin
            if (hold_q != 8'd0) begin
              hold_d = hold_q - 8'd1;
            end
            if (diff[0]) begin
              last_d  = pos;
              delta_d = diff[1] ? delta_q + 8'd1 : delta_q - 8'd1;
            end
          end
        end
        OP_READ_COUNT: begin
          rsp_o.valid      = 1'b1;
          rsp_o.data.count = $signed(detents);
          delta_d          = delta_q & rem_mask;
        end
        OP_READ_BUTTON: begin
          rsp_o.valid = 1'b1;
          if (press_match) begin
            rsp_o.data.press_event = 1'b1;
            hold_d                 = hold_q - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= STEPS_MODE_RST;
      hold_ticks_q <= HOLD_TICKS_RST;
      delta_q      <= '0;
      last_q       <= '0;
      hold_q       <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_STEPS_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_HOLD_TICKS) begin
        hold_ticks_q <= cfg_data_i;
      end
      delta_q <= delta_d;
      last_q  <= last_d;
      hold_q  <= hold_d;
    end
  end

endmodule

@@ sv/qeb_out_skid.sv @@
// qeb_out_skid: result register plus skid entry toward the output channel
// depends on qeb_pkg and qeb_stream_if

module qeb_out_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qeb_pkg::rsp_t rsp_i,
  output logic          ready_o,
  qeb_stream_if.source  out_o
);
  import qeb_pkg::*;

  logic     out_valid_q;
  out_rsp_t out_data_q;
  logic     skid_valid_q;
  out_rsp_t skid_data_q;
  logic     advance;

  // output register may take new data when empty or drained this cycle
  assign advance   = !out_valid_q || out_o.ready;
  assign ready_o   = !skid_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q  <= skid_valid_q || rsp_i.valid;
      skid_valid_q <= 1'b0;
    end else if (rsp_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= skid_valid_q ? skid_data_q : rsp_i.data;
    end else if (rsp_i.valid) begin
      skid_data_q <= rsp_i.data;
    end
  end

endmodule

@@ sv/quadrature_encoder_with_button_unit.sv @@
// quadrature encoder decoder with push button
// a read request's result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one request per cycle while the skid entry is empty, set by the state update in qeb_core
// a stalled result parks in a one-entry skid stage; input ready drops only while it is full
// reset (async, active low) clears delta, position, hold counter and loads config defaults
// depends on qeb_pkg, qeb_stream_if, qeb_core, qeb_out_skid

module quadrature_encoder_with_button_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qeb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qeb_pkg::CfgDataW-1:0] cfg_data_i,
  qeb_stream_if.sink                   in_i,
  qeb_stream_if.source                 out_o
);
  import qeb_pkg::*;

  rsp_t rsp;
  logic ready;
  logic req_fire;

  assign in_i.ready = ready;
  assign req_fire   = in_i.valid && ready;

  qeb_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_fire_i (req_fire),
    .req_i      (in_i.data),
    .rsp_o      (rsp)
  );

  qeb_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rsp_i   (rsp),
    .ready_o (ready),
    .out_o   (out_o)
  );

endmodule

@@ sv/qeb_checker.sv @@
// qeb_checker: port-level assertions for the encoder block, bound to the top level
// depends on qeb_pkg and quadrature_encoder_with_button_unit

module qeb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [1:0]          in_opcode_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic signed [7:0]   out_count_i,
  input logic                out_press_i
);
  import qeb_pkg::*;

  logic in_fire;
  logic read_req;

  assign in_fire  = in_valid_i && in_ready_i;
  assign read_req = (in_opcode_i == OP_READ_COUNT) || (in_opcode_i == OP_READ_BUTTON);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  // a read accepted with the output free shows up next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && read_req && (!out_valid_i || out_ready_i)) |=> out_valid_i)
    else $error("read request produced no result");

  // button results never carry a count
  a_press_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_press_i) |-> (out_count_i == 8'sd0))
    else $error("press event with nonzero count");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_count_i) && $stable(out_press_i)))
    else $error("stalled result changed");

endmodule

bind quadrature_encoder_with_button_unit qeb_checker u_qeb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.data.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_count_i (out_o.data.count),
  .out_press_i (out_o.data.press_event)
);

@@ tb/quadrature_encoder_with_button_unit_tb.sv @@
// testbench for quadrature_encoder_with_button_unit: directed table, then random phases per config
// predicts count and button reads in-line or takes them from the directed table, and checks the results in order
// depends on qeb_pkg, qeb_stream_if and the RTL of the block

module quadrature_encoder_with_button_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qeb_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [1:0] MODE_FOUR_STEP = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam int         CLK_HALF       = 10;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         PHASE_ITEMS    = 320;

  typedef struct packed {
    logic [1:0]        op;
    logic              a;
    logic              b;
    logic              btn;
    logic              typed;
    logic signed [7:0] cnt;
    logic              press;
  } dir_row_t;

  // op, a, b, btn, typed, count, press
  localparam dir_row_t DIR_TAB [18] = '{
    '{OP_READ_COUNT,  1'b0, 1'b0, 1'b0, 1'b1, 8'sd0, 1'b0},
    '{OP_READ_BUTTON, 1'b0, 1'b0, 1'b0, 1'b1, 8'sd0, 1'b0},
    '{OP_TICK,        1'b0, 1'b1, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b1, 1'b1, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b1, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_READ_COUNT,  1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b1, 1'b1, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b1, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b1, 1'b1, 1'b1, 1'b0, 8'sd0, 1'b0},
    '{OP_READ_BUTTON, 1'b0, 1'b0, 1'b0, 1'b1, 8'sd0, 1'b1},
    '{OP_READ_BUTTON, 1'b0, 1'b0, 1'b0, 1'b1, 8'sd0, 1'b0},
    '{OP_TICK,        1'b0, 1'b0, 1'b1, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0},
    '{OP_UNUSED,      1'b1, 1'b1, 1'b1, 1'b0, 8'sd0, 1'b0},
    '{OP_READ_COUNT,  1'b1, 1'b1, 1'b1, 1'b0, 8'sd0, 1'b0},
    '{OP_READ_BUTTON, 1'b1, 1'b1, 1'b1, 1'b0, 8'sd0, 1'b0},
    '{OP_TICK,        1'b0, 1'b1, 1'b0, 1'b0, 8'sd0, 1'b0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  qeb_stream_if #(.T(in_req_t))  req_if ();
  qeb_stream_if #(.T(out_rsp_t)) rsp_if ();

  quadrature_encoder_with_button_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // decoder state as the block should hold it
  logic [7:0] detent_acc;
  logic [1:0] last_pos;
  logic [7:0] hold_cnt;
  logic [1:0] cfg_mode;
  logic [7:0] cfg_hold;

  out_rsp_t    pending_reads_q [$];
  out_rsp_t    mon_want;
  int unsigned err_cnt = 0;
  int unsigned sent_items = 0;
  int unsigned burst_left;
  int unsigned stall_ctr = 0;
  int unsigned stall_style = 0;
  int unsigned stall_left = 0;

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t: %s", $realtime, msg);
  endtask

  task automatic decode_request(input in_req_t r, output bit has_rsp, output out_rsp_t rsp);
    logic [1:0]  pos;
    logic [1:0]  diff;
    int unsigned sh;
    has_rsp = 1'b0;
    rsp = '0;
    case (r.opcode)
      OP_TICK: begin
        if (r.button_pressed) begin
          // phases are not sampled while the button is held
          if (hold_cnt == 8'd0) hold_cnt = cfg_hold;
        end else begin
          if (hold_cnt != 8'd0) hold_cnt = hold_cnt - 8'd1;
          pos  = {r.phase_a, r.phase_a ^ r.phase_b};
          diff = last_pos - pos;
          if (diff[0]) begin
            last_pos   = pos;
            detent_acc = diff[1] ? detent_acc + 8'd1 : detent_acc - 8'd1;
          end
        end
      end
      OP_READ_COUNT: begin
        sh = (cfg_mode == MODE_SPARE) ? 2 : int'(cfg_mode);
        rsp.count  = $signed(detent_acc) >>> sh;
        // remainder below one detent stays behind
        detent_acc = detent_acc & ~(8'hFF << sh);
        has_rsp = 1'b1;
      end
      OP_READ_BUTTON: begin
        if (hold_cnt == cfg_hold) begin
          hold_cnt = hold_cnt - 8'd1;
          rsp.press_event = 1'b1;
        end
        has_rsp = 1'b1;
      end
      default: ;
    endcase
  endtask

  // drive one request from a falling edge, return at a falling edge
  task automatic push_req(input in_req_t r, input bit typed, input out_rsp_t typed_rsp);
    bit       has_rsp;
    out_rsp_t rsp;
    req_if.data  = r;
    req_if.valid = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    decode_request(r, has_rsp, rsp);
    if (has_rsp) pending_reads_q.push_back(typed ? typed_rsp : rsp);
    if (r.opcode != OP_UNUSED) sent_items++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
    end
  endtask

  task automatic tick_pos(input logic [1:0] pos, input logic btn);
    push_req('{opcode: OP_TICK, phase_a: pos[1], phase_b: pos[1] ^ pos[0],
               button_pressed: btn}, 1'b0, '0);
  endtask

  // the pin fields are junk on reads
  task automatic read_op(input logic [1:0] op);
    push_req(in_req_t'({op, 3'($urandom_range(0, 7))}), 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    if (idx == CFG_STEPS_MODE) cfg_mode = val[1:0];
    else if (idx == CFG_HOLD_TICKS) cfg_hold = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (pending_reads_q.size() != 0) @(posedge clk_i);
    // a trailing tick may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    bit          fwd;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // turn the knob, sometimes far enough to wrap the delta
          fwd = 1'($urandom_range(0, 1));
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 300) : $urandom_range(1, 12);
          repeat (len) begin
            if ($urandom_range(0, 15) == 0) fwd = !fwd;
            tick_pos(fwd ? last_pos + 2'd1 : last_pos - 2'd1, 1'b0);
          end
          if ($urandom_range(0, 1) == 1) read_op(OP_READ_COUNT);
        end
        4, 5: begin
          // press, poll the event, release
          repeat ($urandom_range(1, 4)) tick_pos(2'($urandom_range(0, 3)), 1'b1);
          repeat ($urandom_range(0, 3)) read_op(OP_READ_BUTTON);
          repeat ($urandom_range(0, 4)) tick_pos(last_pos, 1'b0);
          read_op(OP_READ_BUTTON);
        end
        6, 7: read_op($urandom_range(0, 1) == 1 ? OP_READ_COUNT : OP_READ_BUTTON);
        8: push_req(in_req_t'(5'($urandom_range(0, 31))), 1'b0, '0);
        default: tick_pos(last_pos + 2'd2, 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // receiver stall pattern, with a randomly redrawn style
  always @(negedge clk_i) begin
    stall_ctr++;
    if (stall_ctr % 96 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: rsp_if.ready = 1'b1;
      1: rsp_if.ready = stall_ctr[0];
      2: rsp_if.ready = ($urandom_range(0, 9) < 6);
      default: begin
        if (stall_left > 0) begin
          rsp_if.ready = 1'b0;
          stall_left--;
        end else begin
          rsp_if.ready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(3, 10);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_reads_q.size() == 0) begin
        report_mismatch($sformatf("result with no read pending: count %0d press %0d",
                                  rsp_if.data.count, rsp_if.data.press_event));
      end else begin
        mon_want = pending_reads_q.pop_front();
        if (rsp_if.data.count !== mon_want.count) begin
          report_mismatch($sformatf("count want %0d got %0d",
                                    mon_want.count, rsp_if.data.count));
        end
        if (rsp_if.data.press_event !== mon_want.press_event) begin
          report_mismatch($sformatf("press_event want %0d got %0d",
                                    mon_want.press_event, rsp_if.data.press_event));
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_STEPS_MODE;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_mode     = STEPS_MODE_RST;
    cfg_hold     = HOLD_TICKS_RST;
    detent_acc   = '0;
    last_pos     = '0;
    hold_cnt     = '0;
    burst_left   = $urandom_range(1, 12);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIR_TAB[i]) begin
      push_req('{opcode: DIR_TAB[i].op, phase_a: DIR_TAB[i].a, phase_b: DIR_TAB[i].b,
                 button_pressed: DIR_TAB[i].btn}, DIR_TAB[i].typed,
               '{count: DIR_TAB[i].cnt, press_event: DIR_TAB[i].press});
    end
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_STEPS_MODE, CfgDataW'(MODE_TWO_STEP));
          write_reg(CFG_HOLD_TICKS, 8'd1);
        end
        1: begin
          write_reg(CFG_STEPS_MODE, CfgDataW'(MODE_FOUR_STEP));
          write_reg(CFG_HOLD_TICKS, 8'd255);
        end
        2: begin
          // spare mode and a zero hold value
          write_reg(CFG_STEPS_MODE, CfgDataW'(MODE_SPARE));
          write_reg(CFG_HOLD_TICKS, 8'd0);
        end
        3: begin
          write_reg(CFG_STEPS_MODE, CfgDataW'(MODE_ONE_STEP));
          write_reg(CFG_HOLD_TICKS, 8'($urandom_range(2, 254)));
        end
        4: begin
          write_reg(CFG_STEPS_MODE, CfgDataW'(MODE_FOUR_STEP));
          write_reg(CFG_HOLD_TICKS, 8'($urandom_range(1, 20)));
        end
        default: begin
          write_reg(CFG_STEPS_MODE, CfgDataW'(MODE_TWO_STEP));
          write_reg(CFG_HOLD_TICKS, HOLD_TICKS_RST);
        end
      endcase
      @(negedge clk_i);
      run_traffic(PHASE_ITEMS);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("quadrature_encoder_with_button_unit_tb: clean");
    end else begin
      $display("quadrature_encoder_with_button_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("quadrature_encoder_with_button_unit_tb: errors");
    $finish;
  end

endmodule
